>>> rtl/stb_pkg.sv
// Shared types and constants of the software timer bank.
// No dependencies; imported by stb_ctrl, software_timer_bank and the testbench.
`default_nettype none

package stb_pkg;

    // Sizing
    localparam int MAX_TIMERS = 128;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_TIMERS);
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int CMP_W      = (CNT_W > 7) ? CNT_W : 7;

    // Command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_CREATE = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_RELOAD = 3'd4;
    localparam logic [2:0] CMD_SET    = 3'd5;
    localparam logic [2:0] CMD_QUERY  = 3'd6;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_UNALLOC = 2'd2;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_SWEEP,
        ST_RESP
    } t_state;

    // One timer entry as held in the table RAM
    typedef struct packed {
        t_count remaining;
        t_count reload;
        logic   enabled;
        logic   expired;
    } t_entry;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  timer_index;
        logic [15:0] interval_ticks;
        logic        auto_start;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] new_index;
        logic       expired;
    } t_rsp;

endpackage

`default_nettype wire

>>> rtl/stb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/stb_ctrl.sv
// Command sequencer of the timer bank: decodes a command, runs the
// read-modify-write on the timer table and the tick sweep.
// Depends on stb_pkg and stb_ram.
`default_nettype none

module stb_ctrl
    import stb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    output logic      o_rsp_valid,
    output t_rsp      o_rsp,
    input  wire logic i_rsp_free
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_ptr, n_ptr;
    logic                  r_pend_vld, n_pend_vld;
    logic [IDX_BITS-1:0]   r_pend_addr, n_pend_addr;
    t_cmd                  r_cmd, n_cmd;
    t_rsp                  r_rsp, n_rsp;

    logic                  ram_we, ram_re;
    logic [IDX_BITS-1:0]   ram_waddr, ram_raddr;
    t_entry                ram_wdata, ram_rdata, ent;

    logic [CMP_W-1:0]      idx_in_ext, idx_reg_ext, cnt_ext;
    logic [31:0]           ivl_in_w, ivl_reg_w;
    t_count                ivl_in, ivl_reg;
    logic                  full, unalloc, sweep_rd;

    stb_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TIMERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign idx_in_ext  = CMP_W'(i_cmd.timer_index);
    assign idx_reg_ext = CMP_W'(r_cmd.timer_index);
    assign cnt_ext     = CMP_W'(r_count);
    assign ivl_in_w    = 32'(i_cmd.interval_ticks);
    assign ivl_reg_w   = 32'(r_cmd.interval_ticks);
    assign ivl_in      = ivl_in_w[COUNT_BITS-1:0];
    assign ivl_reg     = ivl_reg_w[COUNT_BITS-1:0];
    assign full        = (r_count == CNT_W'(MAX_TIMERS));
    assign unalloc     = (idx_in_ext >= cnt_ext);
    assign sweep_rd    = (r_ptr < r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_pend_addr <= n_pend_addr;
        r_cmd       <= n_cmd;
        r_rsp       <= n_rsp;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend_vld  = 1'b0;
        n_pend_addr = r_pend_addr;
        n_cmd       = r_cmd;
        n_rsp       = r_rsp;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        ent         = ram_rdata;
        o_ready     = 1'b0;
        o_rsp_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_cmd = i_cmd;
                    n_rsp = '{status: STAT_OK, new_index: '0, expired: 1'b0};
                    n_state = ST_RESP;
                    case (i_cmd.command)
                        CMD_TICK: begin
                            if (r_count != '0) begin
                                n_ptr   = '0;
                                n_state = ST_SWEEP;
                            end
                        end
                        CMD_CREATE: begin
                            if (full) begin
                                n_rsp.status = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[IDX_BITS-1:0];
                                ram_wdata = '{remaining: ivl_in, reload: ivl_in,
                                              enabled: i_cmd.auto_start,
                                              expired: 1'b0};
                                n_count   = r_count + 1'b1;
                                n_rsp.new_index = cnt_ext[6:0];
                            end
                        end
                        CMD_START, CMD_STOP, CMD_RELOAD, CMD_SET, CMD_QUERY: begin
                            if (unalloc) begin
                                n_rsp.status = STAT_UNALLOC;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = idx_in_ext[IDX_BITS-1:0];
                                n_state   = ST_OP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_OP: begin
                // table data for the addressed timer arrived this cycle
                ram_waddr = idx_reg_ext[IDX_BITS-1:0];
                ram_we    = 1'b1;
                case (r_cmd.command)
                    CMD_START:  ent.enabled = 1'b1;
                    CMD_STOP:   ent.enabled = 1'b0;
                    CMD_RELOAD: ent.remaining = ram_rdata.reload;
                    CMD_SET: begin
                        ent.reload    = ivl_reg;
                        ent.remaining = ivl_reg;
                    end
                    default: begin
                        ram_we        = 1'b0;
                        n_rsp.expired = ram_rdata.expired;
                    end
                endcase
                ram_wdata = ent;
                n_state   = ST_RESP;
            end

            ST_SWEEP: begin
                // read entry r_ptr while writing back entry r_ptr-1
                if (sweep_rd) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_ptr[IDX_BITS-1:0];
                    n_ptr       = r_ptr + 1'b1;
                    n_pend_vld  = 1'b1;
                    n_pend_addr = r_ptr[IDX_BITS-1:0];
                end
                if (r_pend_vld) begin
                    if (ram_rdata.remaining == '0) begin
                        ent.expired   = 1'b1;
                        ent.remaining = ram_rdata.reload;
                    end else begin
                        if (ram_rdata.enabled) begin
                            ent.remaining = ram_rdata.remaining - 1'b1;
                        end
                        ent.expired = 1'b0;
                    end
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_addr;
                    ram_wdata = ent;
                end
                if (!sweep_rd && !r_pend_vld) begin
                    n_state = ST_RESP;
                end
            end

            ST_RESP: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    assign o_rsp = r_rsp;

    // Assertions
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TIMERS))
        else $error("timer count beyond bank size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> (r_count == $past(r_count) + 1'b1))
        else $error("timer count changed other than by one create");

    a_pend_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (CNT_W'(r_pend_addr) < r_count))
        else $error("sweep writes an unallocated entry");

    a_full_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && r_rsp.status == STAT_FULL)
            |-> (r_count == CNT_W'(MAX_TIMERS)))
        else $error("bank full reported while not full");

endmodule

`default_nettype wire

>>> rtl/software_timer_bank.sv
// Top level of the software timer bank: ports, input decode, result register.
// Depends on stb_pkg and stb_ctrl.
`default_nettype none

// A bank of MAX_TIMERS countdown timers kept in one table RAM (remaining
// count, interval, enable and expired bit per entry), driven by tick
// commands from the host. One command is taken at a time; o_in_ready is
// high while the sequencer is idle. Create, bank full, unallocated index,
// the unused code and a tick with no timers are answered without a table
// read; start, stop, reload and set interval read the entry and write it
// back, and query only reads it; a tick sweeps the allocated entries,
// reading one entry per cycle through the single read port while writing
// back the previous one, then does the last write-back and closes the sweep.
// The result sits in an output register, so the next command is accepted
// while it waits; a second result stalls in the sequencer until that
// register frees up. Table entries need no clearing after reset: an entry
// is only read once a create has written it.
module software_timer_bank
    import stb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [6:0]  i_timer_index,
    input  wire logic [15:0] i_interval_ticks,
    input  wire logic        i_auto_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [6:0]       o_new_index,
    output logic             o_expired
);

    t_cmd  cmd;
    t_rsp  rsp;
    logic  rsp_valid, rsp_free, ready, start;
    logic  r_out_valid;
    t_rsp  r_out;

    assign cmd   = '{command: i_command, timer_index: i_timer_index,
                     interval_ticks: i_interval_ticks, auto_start: i_auto_start};
    assign start = i_in_valid && ready;

    stb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (cmd),
        .o_ready     (ready),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_rsp_free  (rsp_free)
    );

    // result register frees up in the cycle its transaction completes
    assign rsp_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_valid && rsp_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_valid && rsp_free) begin
            r_out <= rsp;
        end
    end

    assign o_in_ready  = ready;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_new_index = r_out.new_index;
    assign o_expired   = r_out.expired;

endmodule

`default_nettype wire

>>> verif/stb_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the software timer bank: keeps its own copy of the timer
// table, predicts one result per accepted command and compares results.
// Depends on stb_pkg.
module stb_checker
    import stb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [6:0]  i_timer_index,
    input  wire logic [15:0] i_interval_ticks,
    input  wire logic        i_auto_start,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_status,
    input  wire logic [6:0]  i_new_index,
    input  wire logic        i_expired,
    output int               o_fail_count,
    output int               o_pending
);

    int     timers_in_use;
    t_count remaining_cnt [MAX_TIMERS];
    t_count interval_cnt  [MAX_TIMERS];
    bit     running_flag  [MAX_TIMERS];
    bit     expired_flag  [MAX_TIMERS];
    t_rsp   expected_rsp  [$];
    int     fail_count = 0;

    // Applies one command to the shadow table and returns its result.
    function automatic t_rsp apply_command(t_cmd c);
        t_rsp   r;
        t_count ivl;
        int     idx;
        r   = '0;
        ivl = t_count'(c.interval_ticks);
        idx = int'(c.timer_index);
        case (c.command)
            CMD_TICK: begin
                for (int t = 0; t < timers_in_use; t++) begin
                    if (remaining_cnt[t] == '0) begin
                        expired_flag[t]  = 1'b1;
                        remaining_cnt[t] = interval_cnt[t];
                    end else begin
                        if (running_flag[t])
                            remaining_cnt[t] = t_count'(remaining_cnt[t] - 1'b1);
                        expired_flag[t] = 1'b0;
                    end
                end
            end
            CMD_CREATE: begin
                if (timers_in_use >= MAX_TIMERS) begin
                    r.status = STAT_FULL;
                end else begin
                    interval_cnt[timers_in_use]  = ivl;
                    remaining_cnt[timers_in_use] = ivl;
                    running_flag[timers_in_use]  = c.auto_start;
                    expired_flag[timers_in_use]  = 1'b0;
                    r.new_index   = 7'(timers_in_use);
                    timers_in_use = timers_in_use + 1;
                end
            end
            CMD_START, CMD_STOP, CMD_RELOAD, CMD_SET, CMD_QUERY: begin
                if (idx >= timers_in_use) begin
                    r.status = STAT_UNALLOC;
                end else begin
                    case (c.command)
                        CMD_START:  running_flag[idx] = 1'b1;
                        CMD_STOP:   running_flag[idx] = 1'b0;
                        CMD_RELOAD: remaining_cnt[idx] = interval_cnt[idx];
                        CMD_SET: begin
                            interval_cnt[idx]  = ivl;
                            remaining_cnt[idx] = ivl;
                        end
                        default:    r.expired = expired_flag[idx];
                    endcase
                end
            end
            default: ;  // unused code: no effect, status ok
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            timers_in_use = 0;
            expected_rsp.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_status, i_new_index, i_expired};
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected result, status %0d new_index %0d expired %0d",
                             $time, got.status, got.new_index, got.expired);
                    fail_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("new_index", want.new_index, got.new_index);
                    check_field("expired", want.expired, got.expired);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_rsp.push_back(apply_command(
                    {i_command, i_timer_index, i_interval_ticks, i_auto_start}));
        end
        o_pending    <= expected_rsp.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Top of the timer bank testbench: clock, reset, command stimulus, result
// back-pressure, watchdog and verdict.
// Depends on stb_pkg, stb_checker and the software_timer_bank RTL.
module tb;
    import stb_pkg::*;

    // Code 7 is not a command; the block must answer it with status ok.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 1225;
    // Longest legit quiet spell is the result hold-off (HOLD_CYCLES) or a
    // full-bank sweep plus idle gaps; take it many times over.
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    // The slowest command is a tick that sweeps a full bank.
    localparam int DRAIN_CYCLES = MAX_TIMERS + 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [6:0]  timer_index;
    logic [15:0] interval_ticks;
    logic        auto_start;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [6:0]  new_index;
    logic        expired;

    int fail_count;
    int pending;

    // Stimulus-side bookkeeping: how many creates the bank should have
    // honored, used to aim indexes mostly at allocated timers.
    int timers_made;
    int items_sent;
    int sent_per_cmd [8];

    // Idle control shared with the result side.
    bit sender_quiet;
    bit receiver_quiet;
    bit hold_request;
    bit hold_done;

    software_timer_bank uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_command        (command),
        .i_timer_index    (timer_index),
        .i_interval_ticks (interval_ticks),
        .i_auto_start     (auto_start),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_new_index      (new_index),
        .o_expired        (expired)
    );

    stb_checker timer_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_command        (command),
        .i_timer_index    (timer_index),
        .i_interval_ticks (interval_ticks),
        .i_auto_start     (auto_start),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_status         (status),
        .i_new_index      (new_index),
        .i_expired        (expired),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Offers one command transaction. Called and returns just after a
    // falling edge; optional idle cycles come first, then valid is held
    // with a steady payload until the block takes it.
    task automatic send_command(input logic [2:0] cmd, input logic [6:0] idx,
                                input logic [15:0] ivl, input logic autos);
        while (!sender_quiet && $urandom_range(99) < 36) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        command        = cmd;
        timer_index    = idx;
        interval_ticks = ivl;
        auto_start     = autos;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (cmd == CMD_CREATE && timers_made < MAX_TIMERS)
            timers_made++;
        sent_per_cmd[cmd]++;
        items_sent++;
    endtask

    // Mostly an allocated timer; now and then any 7-bit index.
    function automatic logic [6:0] pick_index();
        if (timers_made == 0 || $urandom_range(99) < 15)
            return 7'($urandom_range(127));
        return 7'($urandom_range(timers_made - 1));
    endfunction

    // Short intervals so that timers actually run out; full range sometimes.
    function automatic logic [15:0] pick_interval();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 16'($urandom_range(4));
        if (r < 85)
            return 16'($urandom_range(40, 5));
        return 16'($urandom_range(65535));
    endfunction

    // Result side: random stalls, a quiet window, and one long hold-off
    // while the sender keeps offering, so the block backs up into its input.
    initial begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request && !hold_done) begin
                out_ready = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            out_ready = receiver_quiet || ($urandom_range(99) >= 36);
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                 idle_run, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int target;
        int roll;
        int k;
        int n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = CMD_TICK;
        timer_index    = '0;
        interval_ticks = '0;
        auto_start     = 1'b0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        hold_request   = 1'b0;
        timers_made    = 0;
        items_sent     = 0;
        foreach (sent_per_cmd[i])
            sent_per_cmd[i] = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- Directed part ----
        // Empty bank: every access is unallocated, a tick sweeps nothing.
        send_command(CMD_QUERY, 7'd0, 16'd0, 1'b0);
        send_command(CMD_TICK, 7'd0, 16'd0, 1'b0);
        send_command(CMD_UNUSED, 7'd127, 16'hFFFF, 1'b1);
        send_command(CMD_START, 7'd127, 16'hFFFF, 1'b1);
        // Zero interval (expires every tick), widest interval stopped, short one running.
        send_command(CMD_CREATE, 7'd0, 16'd0, 1'b1);
        send_command(CMD_CREATE, 7'd127, 16'hFFFF, 1'b0);
        send_command(CMD_CREATE, 7'd0, 16'd2, 1'b1);
        send_command(CMD_TICK, 7'd0, 16'd0, 1'b0);
        send_command(CMD_QUERY, 7'd0, 16'd0, 1'b0);
        send_command(CMD_QUERY, 7'd1, 16'd0, 1'b0);
        repeat (3) send_command(CMD_TICK, 7'd0, 16'd0, 1'b0);
        send_command(CMD_QUERY, 7'd2, 16'd0, 1'b0);
        // Stop, start, set interval and reload on live timers.
        send_command(CMD_STOP, 7'd2, 16'd0, 1'b0);
        send_command(CMD_TICK, 7'd0, 16'd0, 1'b0);
        send_command(CMD_START, 7'd1, 16'd0, 1'b0);
        send_command(CMD_SET, 7'd1, 16'd1, 1'b0);
        send_command(CMD_RELOAD, 7'd2, 16'd0, 1'b0);
        send_command(CMD_QUERY, 7'd2, 16'd0, 1'b0);
        send_command(CMD_QUERY, 7'd1, 16'd0, 1'b0);
        // Indexes past the allocated count.
        send_command(CMD_STOP, 7'd3, 16'd0, 1'b0);
        send_command(CMD_RELOAD, 7'd5, 16'hFFFF, 1'b1);
        send_command(CMD_SET, 7'd100, 16'h5A5A, 1'b0);
        send_command(CMD_QUERY, 7'd127, 16'd0, 1'b0);

        // ---- Random part ----
        // Creates are frequent enough that the bank fills and full-bank
        // creates get exercised late in the run.
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            sender_quiet   = (items_sent > 350 && items_sent < 550);
            receiver_quiet = sender_quiet;
            if (items_sent > 800)
                hold_request = 1'b1;
            roll = $urandom_range(99);
            if (roll < 5 && timers_made > 0) begin
                // Countdown run: set a short interval on one timer, start it,
                // then tick past expiry and query after every tick. Unused
                // fields carry noise.
                k = $urandom_range(timers_made - 1);
                n = $urandom_range(5);
                send_command(CMD_SET, 7'(k), 16'(n), 1'($urandom_range(1)));
                send_command(CMD_START, 7'(k), 16'($urandom_range(65535)),
                             1'($urandom_range(1)));
                for (int j = 0; j <= n + 1; j++) begin
                    send_command(CMD_TICK, 7'($urandom_range(127)),
                                 16'($urandom_range(65535)), 1'($urandom_range(1)));
                    send_command(CMD_QUERY, 7'(k), 16'($urandom_range(65535)),
                                 1'($urandom_range(1)));
                end
            end else begin
                roll = $urandom_range(99);
                if (roll < 28)
                    send_command(CMD_TICK, pick_index(), pick_interval(),
                                 1'($urandom_range(1)));
                else if (roll < 48)
                    send_command(CMD_CREATE, pick_index(), pick_interval(),
                                 1'($urandom_range(1)));
                else if (roll < 56)
                    send_command(CMD_START, pick_index(), pick_interval(),
                                 1'($urandom_range(1)));
                else if (roll < 64)
                    send_command(CMD_STOP, pick_index(), pick_interval(),
                                 1'($urandom_range(1)));
                else if (roll < 71)
                    send_command(CMD_RELOAD, pick_index(), pick_interval(),
                                 1'($urandom_range(1)));
                else if (roll < 80)
                    send_command(CMD_SET, pick_index(), pick_interval(),
                                 1'($urandom_range(1)));
                else if (roll < 97)
                    send_command(CMD_QUERY, pick_index(), pick_interval(),
                                 1'($urandom_range(1)));
                else
                    send_command(CMD_UNUSED, pick_index(), pick_interval(),
                                 1'($urandom_range(1)));
            end
        end
        in_valid       = 1'b0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;

        // Drain: every result in, then room for a full sweep to leak a stray one.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d commands: %0d ticks, %0d creates, %0d queries, %0d start/stop/reload/set, %0d unused codes",
                 items_sent, sent_per_cmd[CMD_TICK], sent_per_cmd[CMD_CREATE],
                 sent_per_cmd[CMD_QUERY],
                 sent_per_cmd[CMD_START] + sent_per_cmd[CMD_STOP] +
                 sent_per_cmd[CMD_RELOAD] + sent_per_cmd[CMD_SET],
                 sent_per_cmd[CMD_UNUSED]);
        $display("Bank reached %0d of %0d timers; result hold-off of %0d cycles done: %0d",
                 timers_made, MAX_TIMERS, HOLD_CYCLES, hold_done);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/stb_pkg.sv
rtl/stb_ram.sv
rtl/stb_ctrl.sv
rtl/software_timer_bank.sv
verif/stb_checker.sv
verif/tb.sv
